/* hw/rtl/chgs_pkg.sv */
// shared types and constants of the convex hull engine
`default_nettype none

package chgs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_W    = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FEW   = 2'd1,
      ST_DEGEN = 2'd2,
      ST_OVF   = 2'd3
   } status_type;

   // side information that travels with a cross product
   typedef struct packed {
      logic last;
      logic skip;
      logic far;
   } cx_tag_type;

   // cross product request: origin o, points a and b
   typedef struct packed {
      logic       valid;
      cx_tag_type tag;
      coord_type  ox;
      coord_type  oy;
      coord_type  ax;
      coord_type  ay;
      coord_type  bx;
      coord_type  by;
   } cx_op_type;

   // cross product result: sign only
   typedef struct packed {
      logic       valid;
      cx_tag_type tag;
      logic       pos;
      logic       zero;
   } cx_res_type;

endpackage

`default_nettype wire

/* hw/rtl/convex_hull_graham_scan.sv */
// top level of the graham scan convex hull engine
//
//  channel | direction | handshake           | payload
//  req     | in        | req_valid/req_ready | point_x, point_y, set_end
//  rsp     | out       | rsp_valid/rsp_ready | hull_x, hull_y, run_end, status
//
// loading a point runs a duplicate scan over the point store
// a final point then starts the ray and ordering passes, each a full
// sweep of the point store read port, and then the stack steps of the scan
// each hull vertex is held on rsp until rsp_ready; one transaction is in flight at a time
// reset is synchronous and empties the point store; memory contents are not cleared
`default_nettype none

module convex_hull_graham_scan (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire chgs_pkg::coord_type           req_point_x,
   input  wire chgs_pkg::coord_type           req_point_y,
   input  wire logic                          req_set_end,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output chgs_pkg::coord_type                rsp_hull_x,
   output chgs_pkg::coord_type                rsp_hull_y,
   output logic                               rsp_run_end,
   output logic [1:0]                         rsp_status
);

   localparam int IW = chgs_pkg::IDX_W;
   localparam int CW = chgs_pkg::CNT_W;

   typedef enum logic [4:0] {
      S_IDLE, S_DUP, S_INS, S_CHK, S_PIV, S_A_RD, S_A_LD, S_B, S_A_WB, S_M_CHK,
      S_K0, S_K1, S_K2, S_P_RD, S_P_SL, S_P_LD, S_CX, S_CXW, S_SEC_SL, S_SEC_LD,
      S_PUSH, S_OUT_RD, S_OUT_SL, S_OUT_LD, S_OUT_W
   } state_type;

   typedef struct packed {
      logic                drop;
      chgs_pkg::coord_type x;
      chgs_pkg::coord_type y;
   } entry_type;

   // point store and order / stack memory
   entry_type     st_mem [chgs_pkg::MAX_POINTS];
   logic [IW-1:0] or_mem [chgs_pkg::MAX_POINTS];

   logic          st_we, or_we;
   logic [IW-1:0] st_waddr, st_raddr, or_waddr, or_raddr, or_wdata;
   entry_type     st_wdata, st_rdata_ff;
   logic [IW-1:0] or_rdata_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in, b_ff, b_in, a_ff, a_in, m_ff, m_in;
   logic [CW-1:0] i_ff, i_in, dep_ff, dep_in, dep_m1, dep_m4;
   logic          ovf_ff, ovf_in, dup_ff, dup_in, inlast_ff, inlast_in;
   chgs_pkg::coord_type inx_ff, inx_in, iny_ff, iny_in;
   logic          rd_vld_ff, rd_vld_in, rd_last_ff, rd_last_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] piv_idx_ff, piv_idx_in;
   chgs_pkg::coord_type piv_x_ff, piv_x_in, piv_y_ff, piv_y_in;
   logic          pass_ff, pass_in, acc_drop_ff, acc_drop_in;
   chgs_pkg::coord_type a_x_ff, a_x_in, a_y_ff, a_y_in;
   logic [IW-1:0] rank_ff, rank_in, p_slot_ff, p_slot_in, k_ff, k_in;
   chgs_pkg::coord_type sec_x_ff, sec_x_in, sec_y_ff, sec_y_in;
   chgs_pkg::coord_type top_x_ff, top_x_in, top_y_ff, top_y_in;
   chgs_pkg::coord_type p_x_ff, p_x_in, p_y_ff, p_y_in;
   logic          rsp_vld_ff, rsp_vld_in, rsp_end_ff, rsp_end_in;
   chgs_pkg::coord_type rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   chgs_pkg::status_type rsp_st_ff, rsp_st_in;
   logic          strm_issue, stack_op;
   chgs_pkg::cx_op_type  cx_op;
   chgs_pkg::cx_res_type cx_res;

   chgs_cross u_cross (
      .clock (clock),
      .reset (reset),
      .op    (cx_op),
      .res   (cx_res)
   );

   assign dep_m1 = dep_ff - CW'(1);
   assign dep_m4 = dep_ff - CW'(4);
   assign strm_issue = ((state_ff == S_DUP) || (state_ff == S_PIV) || (state_ff == S_B))
                       && (b_ff < cnt_ff);
   assign stack_op = (state_ff == S_CX);

   // cross product operands: stack scan or streamed pass
   always_comb begin
      cx_op.valid    = stack_op ? (dep_ff >= CW'(2)) : ((state_ff == S_B) && rd_vld_ff);
      cx_op.tag.last = stack_op ? 1'b0 : rd_last_ff;
      cx_op.tag.skip = stack_op ? 1'b0 : ((rd_idx_ff == piv_idx_ff) ||
                                          (rd_idx_ff == a_ff[IW-1:0]) ||
                                          (pass_ff && st_rdata_ff.drop));
      cx_op.tag.far  = stack_op ? 1'b0 : ((st_rdata_ff.y > a_y_ff) ||
                                          ((st_rdata_ff.y == a_y_ff) &&
                                           (st_rdata_ff.x > a_x_ff)));
      cx_op.ox = stack_op ? sec_x_ff : piv_x_ff;
      cx_op.oy = stack_op ? sec_y_ff : piv_y_ff;
      cx_op.ax = stack_op ? top_x_ff : a_x_ff;
      cx_op.ay = stack_op ? top_y_ff : a_y_ff;
      cx_op.bx = stack_op ? p_x_ff : st_rdata_ff.x;
      cx_op.by = stack_op ? p_y_ff : st_rdata_ff.y;
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;  cnt_in = cnt_ff;  b_in = b_ff;  a_in = a_ff;  m_in = m_ff;
      i_in = i_ff;  dep_in = dep_ff;  ovf_in = ovf_ff;  dup_in = dup_ff;
      inlast_in = inlast_ff;  inx_in = inx_ff;  iny_in = iny_ff;
      piv_idx_in = piv_idx_ff;  piv_x_in = piv_x_ff;  piv_y_in = piv_y_ff;
      pass_in = pass_ff;  acc_drop_in = acc_drop_ff;  a_x_in = a_x_ff;  a_y_in = a_y_ff;
      rank_in = rank_ff;  p_slot_in = p_slot_ff;  k_in = k_ff;
      sec_x_in = sec_x_ff;  sec_y_in = sec_y_ff;  top_x_in = top_x_ff;  top_y_in = top_y_ff;
      p_x_in = p_x_ff;  p_y_in = p_y_ff;
      rsp_vld_in = rsp_vld_ff;  rsp_end_in = rsp_end_ff;  rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;  rsp_st_in = rsp_st_ff;
      st_we = 1'b0;  st_waddr = a_ff[IW-1:0];
      st_wdata = '{drop: acc_drop_ff, x: a_x_ff, y: a_y_ff};
      st_raddr = b_ff[IW-1:0];
      or_we = 1'b0;  or_waddr = rank_ff;  or_wdata = a_ff[IW-1:0];  or_raddr = '0;
      rd_vld_in  = strm_issue;
      rd_last_in = (b_ff == cnt_ff - CW'(1));
      rd_idx_in  = b_ff[IW-1:0];
      if (strm_issue) begin
         b_in = b_ff + CW'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               inx_in    = req_point_x;
               iny_in    = req_point_y;
               inlast_in = req_set_end;
               dup_in    = 1'b0;
               b_in      = '0;
               state_in  = (cnt_ff == '0) ? S_INS : S_DUP;
            end
         end
         // compare against every stored point
         S_DUP: begin
            if (rd_vld_ff && (st_rdata_ff.x == inx_ff) && (st_rdata_ff.y == iny_ff)) begin
               dup_in = 1'b1;
            end
            if (rd_vld_ff && rd_last_ff) begin
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (!dup_ff) begin
               if (cnt_ff < CW'(chgs_pkg::MAX_POINTS)) begin
                  st_we    = 1'b1;
                  st_waddr = cnt_ff[IW-1:0];
                  st_wdata = '{drop: 1'b0, x: inx_ff, y: iny_ff};
                  cnt_in   = cnt_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = inlast_ff ? S_CHK : S_IDLE;
         end
         S_CHK: begin
            if (ovf_ff || (cnt_ff < CW'(3))) begin
               rsp_vld_in = 1'b1;
               rsp_end_in = 1'b1;
               rsp_x_in   = '0;
               rsp_y_in   = '0;
               rsp_st_in  = ovf_ff ? chgs_pkg::ST_OVF : chgs_pkg::ST_FEW;
               state_in   = S_OUT_W;
            end else begin
               b_in     = '0;
               state_in = S_PIV;
            end
         end
         // lowest y, then lowest x
         S_PIV: begin
            if (rd_vld_ff && ((rd_idx_ff == '0) || (st_rdata_ff.y < piv_y_ff) ||
                              ((st_rdata_ff.y == piv_y_ff) && (st_rdata_ff.x < piv_x_ff)))) begin
               piv_idx_in = rd_idx_ff;
               piv_x_in   = st_rdata_ff.x;
               piv_y_in   = st_rdata_ff.y;
            end
            if (rd_vld_ff && rd_last_ff) begin
               pass_in  = 1'b0;
               a_in     = '0;
               m_in     = '0;
               state_in = S_A_RD;
            end
         end
         // outer loop of the ray and ordering passes
         S_A_RD: begin
            if (a_ff == cnt_ff) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  a_in    = '0;
               end else begin
                  state_in = S_M_CHK;
               end
            end else if (a_ff[IW-1:0] == piv_idx_ff) begin
               a_in = a_ff + CW'(1);
            end else begin
               st_raddr = a_ff[IW-1:0];
               state_in = S_A_LD;
            end
         end
         S_A_LD: begin
            a_x_in = st_rdata_ff.x;
            a_y_in = st_rdata_ff.y;
            if (pass_ff && st_rdata_ff.drop) begin
               a_in     = a_ff + CW'(1);
               state_in = S_A_RD;
            end else begin
               b_in        = '0;
               acc_drop_in = 1'b0;
               rank_in     = '0;
               state_in    = S_B;
            end
         end
         // inner sweep: farther point on same ray, or count of earlier rays
         S_B: begin
            if (cx_res.valid && !cx_res.tag.skip) begin
               if (!pass_ff && cx_res.zero && cx_res.tag.far) begin
                  acc_drop_in = 1'b1;
               end
               if (pass_ff && !cx_res.pos && !cx_res.zero) begin
                  rank_in = rank_ff + IW'(1);
               end
            end
            if (cx_res.valid && cx_res.tag.last) begin
               state_in = S_A_WB;
            end
         end
         S_A_WB: begin
            if (!pass_ff) begin
               st_we = 1'b1;
            end else begin
               or_we = 1'b1;
               m_in  = m_ff + CW'(1);
            end
            a_in     = a_ff + CW'(1);
            state_in = S_A_RD;
         end
         S_M_CHK: begin
            if (m_ff < CW'(2)) begin
               rsp_vld_in = 1'b1;
               rsp_end_in = 1'b1;
               rsp_x_in   = '0;
               rsp_y_in   = '0;
               rsp_st_in  = chgs_pkg::ST_DEGEN;
               state_in   = S_OUT_W;
            end else begin
               or_raddr = '0;
               state_in = S_K0;
            end
         end
         // stack starts as pivot, order[0], order[1]
         S_K0: begin
            st_raddr = or_rdata_ff;
            or_raddr = IW'(1);
            state_in = S_K1;
         end
         S_K1: begin
            sec_x_in = st_rdata_ff.x;
            sec_y_in = st_rdata_ff.y;
            st_raddr = or_rdata_ff;
            state_in = S_K2;
         end
         S_K2: begin
            top_x_in = st_rdata_ff.x;
            top_y_in = st_rdata_ff.y;
            dep_in   = CW'(3);
            i_in     = CW'(2);
            state_in = S_P_RD;
         end
         S_P_RD: begin
            if (i_ff == m_ff) begin
               k_in     = dep_m1[IW-1:0];
               state_in = S_OUT_RD;
            end else begin
               or_raddr = i_ff[IW-1:0];
               state_in = S_P_SL;
            end
         end
         S_P_SL: begin
            p_slot_in = or_rdata_ff;
            st_raddr  = or_rdata_ff;
            state_in  = S_P_LD;
         end
         S_P_LD: begin
            p_x_in   = st_rdata_ff.x;
            p_y_in   = st_rdata_ff.y;
            state_in = S_CX;
         end
         S_CX: begin
            state_in = (dep_ff < CW'(2)) ? S_PUSH : S_CXW;
         end
         // pop on a non-left turn
         S_CXW: begin
            if (cx_res.valid) begin
               if (!cx_res.pos) begin
                  dep_in   = dep_m1;
                  top_x_in = sec_x_ff;
                  top_y_in = sec_y_ff;
                  if (dep_ff == CW'(3)) begin
                     sec_x_in = piv_x_ff;
                     sec_y_in = piv_y_ff;
                     state_in = S_CX;
                  end else if (dep_ff > CW'(3)) begin
                     or_raddr = dep_m4[IW-1:0];
                     state_in = S_SEC_SL;
                  end else begin
                     state_in = S_CX;
                  end
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_SEC_SL: begin
            st_raddr = or_rdata_ff;
            state_in = S_SEC_LD;
         end
         S_SEC_LD: begin
            sec_x_in = st_rdata_ff.x;
            sec_y_in = st_rdata_ff.y;
            state_in = S_CX;
         end
         // stack entry k lives at order address k-1
         S_PUSH: begin
            or_we    = 1'b1;
            or_waddr = dep_m1[IW-1:0];
            or_wdata = p_slot_ff;
            dep_in   = dep_ff + CW'(1);
            sec_x_in = top_x_ff;
            sec_y_in = top_y_ff;
            top_x_in = p_x_ff;
            top_y_in = p_y_ff;
            i_in     = i_ff + CW'(1);
            state_in = S_P_RD;
         end
         // emit stack from top down
         S_OUT_RD: begin
            if (k_ff == '0) begin
               rsp_vld_in = 1'b1;
               rsp_end_in = 1'b1;
               rsp_x_in   = piv_x_ff;
               rsp_y_in   = piv_y_ff;
               rsp_st_in  = chgs_pkg::ST_OK;
               state_in   = S_OUT_W;
            end else begin
               or_raddr = k_ff - IW'(1);
               state_in = S_OUT_SL;
            end
         end
         S_OUT_SL: begin
            st_raddr = or_rdata_ff;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_vld_in = 1'b1;
            rsp_end_in = 1'b0;
            rsp_x_in   = st_rdata_ff.x;
            rsp_y_in   = st_rdata_ff.y;
            rsp_st_in  = chgs_pkg::ST_OK;
            state_in   = S_OUT_W;
         end
         S_OUT_W: begin
            if (rsp_ready) begin
               rsp_vld_in = 1'b0;
               if (rsp_end_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff - IW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_waddr] <= st_wdata;
      end
      st_rdata_ff <= st_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (or_we) begin
         or_mem[or_waddr] <= or_wdata;
      end
      or_rdata_ff <= or_mem[or_raddr];
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      b_ff <= b_in;  a_ff <= a_in;  m_ff <= m_in;  i_ff <= i_in;  dep_ff <= dep_in;
      dup_ff <= dup_in;  inlast_ff <= inlast_in;  inx_ff <= inx_in;  iny_ff <= iny_in;
      rd_last_ff <= rd_last_in;  rd_idx_ff <= rd_idx_in;
      piv_idx_ff <= piv_idx_in;  piv_x_ff <= piv_x_in;  piv_y_ff <= piv_y_in;
      pass_ff <= pass_in;  acc_drop_ff <= acc_drop_in;  a_x_ff <= a_x_in;  a_y_ff <= a_y_in;
      rank_ff <= rank_in;  p_slot_ff <= p_slot_in;  k_ff <= k_in;
      sec_x_ff <= sec_x_in;  sec_y_ff <= sec_y_in;  top_x_ff <= top_x_in;
      top_y_ff <= top_y_in;  p_x_ff <= p_x_in;  p_y_ff <= p_y_in;
      rsp_end_ff <= rsp_end_in;  rsp_x_ff <= rsp_x_in;  rsp_y_ff <= rsp_y_in;
      rsp_st_ff <= rsp_st_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_vld_ff;
   assign rsp_hull_x  = rsp_x_ff;
   assign rsp_hull_y  = rsp_y_ff;
   assign rsp_run_end = rsp_end_ff;
   assign rsp_status  = rsp_st_ff;

`ifndef SYNTHESIS
   // point count never passes the store depth
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(chgs_pkg::MAX_POINTS))
      else $error("point count beyond store depth");

   // a result is only shown while the sequencer waits for it
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (state_ff == S_OUT_W))
      else $error("result valid outside output wait");

   // in-place stack never overtakes the unread order entries
   a_stack_inplace: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |-> (dep_ff <= i_ff + CW'(1)))
      else $error("stack write over unread order entry");

   // error results carry a zero vertex and close the run
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_st_ff != chgs_pkg::ST_OK)) |->
         (rsp_end_ff && (rsp_x_ff == '0) && (rsp_y_ff == '0)))
      else $error("malformed error result");

   // a stack turn test returns after the cross unit latency
   a_cx_latency: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_CX) && (dep_ff >= CW'(2))) |-> ##3 cx_res.valid)
      else $error("cross result missing");
`endif

endmodule

`default_nettype wire

/* hw/rtl/chgs_cross.sv */
// three-stage pipelined cross product sign unit
`default_nettype none

module chgs_cross (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire chgs_pkg::cx_op_type  op,
   output chgs_pkg::cx_res_type      res
);

   // stage 1: differences
   logic                                   s1_vld_ff;
   chgs_pkg::cx_tag_type                   s1_tag_ff;
   logic signed [chgs_pkg::DIFF_W-1:0]     dax_ff, day_ff, dbx_ff, dby_ff;
   // stage 2: products
   logic                                   s2_vld_ff;
   chgs_pkg::cx_tag_type                   s2_tag_ff;
   logic signed [chgs_pkg::PROD_W-1:0]     p1_ff, p2_ff;
   // stage 3: sign of the difference
   logic                                   s3_vld_ff;
   chgs_pkg::cx_tag_type                   s3_tag_ff;
   logic                                   pos_ff, zero_ff;

   logic signed [chgs_pkg::DIFF_W-1:0]     dax_in, day_in, dbx_in, dby_in;
   logic signed [chgs_pkg::PROD_W-1:0]     p1_in, p2_in;
   logic signed [chgs_pkg::CROSS_W-1:0]    c_val;

   assign dax_in = chgs_pkg::DIFF_W'(op.ax) - chgs_pkg::DIFF_W'(op.ox);
   assign day_in = chgs_pkg::DIFF_W'(op.ay) - chgs_pkg::DIFF_W'(op.oy);
   assign dbx_in = chgs_pkg::DIFF_W'(op.bx) - chgs_pkg::DIFF_W'(op.ox);
   assign dby_in = chgs_pkg::DIFF_W'(op.by) - chgs_pkg::DIFF_W'(op.oy);
   assign p1_in  = chgs_pkg::PROD_W'(dax_ff) * chgs_pkg::PROD_W'(dby_ff);
   assign p2_in  = chgs_pkg::PROD_W'(day_ff) * chgs_pkg::PROD_W'(dbx_ff);
   assign c_val  = chgs_pkg::CROSS_W'(p1_ff) - chgs_pkg::CROSS_W'(p2_ff);

   always_ff @(posedge clock) begin
      dax_ff    <= dax_in;
      day_ff    <= day_in;
      dbx_ff    <= dbx_in;
      dby_ff    <= dby_in;
      s1_tag_ff <= op.tag;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      s2_tag_ff <= s1_tag_ff;
      pos_ff    <= !c_val[chgs_pkg::CROSS_W-1] && (c_val != '0);
      zero_ff   <= (c_val == '0);
      s3_tag_ff <= s2_tag_ff;
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= op.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   assign res.valid = s3_vld_ff;
   assign res.tag   = s3_tag_ff;
   assign res.pos   = pos_ff;
   assign res.zero  = zero_ff;

endmodule

`default_nettype wire
